FILE: hdl/crc32te_pkg.sv
// ----------------------------------------------------------------------------
// crc32te_pkg
// constants and table-entry helpers shared by the crc-32 engine
// ----------------------------------------------------------------------------
package crc32te_pkg;

    localparam int CRC_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [CRC_W-1:0] DEFAULT_POLY = 32'h04C1_1DB7;
    localparam logic [TABLE_AW-1:0] TABLE_LAST = TABLE_AW'(TABLE_DEPTH - 1);

    // bit-reverse a byte
    function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[k] = v[BYTE_W-1-k];
        end
        return r;
    endfunction

    // bit-reverse a crc word
    function automatic logic [CRC_W-1:0] mirror32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    // one reflected table entry: eight msb-first polynomial steps
    function automatic logic [CRC_W-1:0] table_entry(input logic [BYTE_W-1:0] idx,
                                                     input logic [CRC_W-1:0]  poly);
        logic [CRC_W-1:0] w;
        w = {mirror8(idx), {(CRC_W-BYTE_W){1'b0}}};
        for (int b = 0; b < BYTE_W; b++) begin
            if (w[CRC_W-1]) begin
                w = {w[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                w = {w[CRC_W-2:0], 1'b0};
            end
        end
        return mirror32(w);
    endfunction

endpackage

FILE: hdl/crc32te_ram.sv
// ----------------------------------------------------------------------------
// crc32te_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module crc32te_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/crc32_table_driven_engine_core.sv
// ----------------------------------------------------------------------------
// crc32_table_driven_engine_core
// reflected byte-wise crc-32 with a programmable generator polynomial
// ----------------------------------------------------------------------------
// Folds one message byte per item into a running reflected CRC-32 through a
// 256 x 32 lookup table held in a synchronous RAM, and returns the running
// CRC (no final xor) for every byte. An item with first_byte set restarts from
// start_value. Writing generator_poly (zero means 0x04C11DB7) makes the table
// stale; the engine then rebuilds all 256 entries in a sweep, one entry per
// cycle, during which no item is accepted. The same sweep runs once after
// reset. Outside a rebuild an item is accepted every cycle unless the output
// stalls: the table read is registered and its result is forwarded straight
// into the address of the next byte, so the sustained rate is one byte per
// clock; a byte goes through the registered table read to the result register.
// ----------------------------------------------------------------------------
module crc32_table_driven_engine_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // polynomial register
    input  logic                             cfg_wr_en,
    input  logic [crc32te_pkg::CRC_W-1:0]    cfg_wr_data,
    // byte input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [crc32te_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                             s_first_byte,
    input  logic [crc32te_pkg::CRC_W-1:0]    s_start_value,
    // crc output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [crc32te_pkg::CRC_W-1:0]    m_crc_value
);

    import crc32te_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_BUILD = 2'b10
    } eng_state_t;

    // control state
    eng_state_t          state_reg, state_next;
    logic [TABLE_AW-1:0] cnt_reg, cnt_next;
    logic [CRC_W-1:0]    gen_poly_reg, gen_poly_next;
    logic [CRC_W-1:0]    table_poly_reg, table_poly_next;
    logic                b_valid_reg, b_valid_next;
    logic                m_valid_reg, m_valid_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    // payload carried beside the table read
    logic [CRC_W-BYTE_W-1:0] hi_reg, hi_next;

    logic [CRC_W-1:0]    eff_poly;
    logic                poly_stale;
    logic                b_adv;
    logic                accept;
    logic [CRC_W-1:0]    rd_data;
    logic [CRC_W-1:0]    fwd_crc;
    logic [CRC_W-1:0]    running;
    logic [CRC_W-1:0]    prior;
    logic [TABLE_AW-1:0] rd_addr;
    logic                tbl_wr_en;
    logic [CRC_W-1:0]    tbl_wr_data;

    // zero in the register selects the standard polynomial
    assign eff_poly   = (gen_poly_reg == '0) ? DEFAULT_POLY : gen_poly_reg;
    assign poly_stale = (eff_poly != table_poly_reg);

    // lookup stage hands its crc to the output register when that is empty or being read
    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);

    // crc of the byte in the lookup stage, forwarded to the next byte
    assign fwd_crc = rd_data ^ {{BYTE_W{1'b0}}, hi_reg};
    assign running = b_valid_reg ? fwd_crc : crc_reg;
    assign prior   = s_first_byte ? s_start_value : running;

    assign s_ready = (state_reg == ST_RUN) && !poly_stale && (!b_valid_reg || b_adv);
    assign accept  = s_valid && s_ready;
    assign rd_addr = prior[TABLE_AW-1:0] ^ s_data_byte;

    // table rebuild writes one entry per cycle
    assign tbl_wr_en   = (state_reg == ST_BUILD);
    assign tbl_wr_data = table_entry(cnt_reg, table_poly_reg);

    crc32te_ram #(
        .WIDTH (CRC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (cnt_reg),
        .wr_data (tbl_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        table_poly_next = table_poly_reg;
        gen_poly_next   = cfg_wr_en ? cfg_wr_data : gen_poly_reg;
        b_valid_next    = b_valid_reg;
        m_valid_next    = m_valid_reg;
        crc_next        = crc_reg;
        hi_next         = hi_reg;

        case (state_reg)
            ST_RUN: begin
                // rebuild only once the lookup stage has drained
                if (poly_stale && !b_valid_reg) begin
                    state_next      = ST_BUILD;
                    cnt_next        = '0;
                    table_poly_next = eff_poly;
                end
            end
            ST_BUILD: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == TABLE_LAST) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        // output register
        if (b_adv) begin
            m_valid_next = 1'b1;
            crc_next     = fwd_crc;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // lookup stage
        if (accept) begin
            b_valid_next = 1'b1;
            hi_next      = prior[CRC_W-1:BYTE_W];
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            cnt_reg        <= '0;
            gen_poly_reg   <= DEFAULT_POLY;
            table_poly_reg <= '0;
            b_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            crc_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            gen_poly_reg   <= gen_poly_next;
            table_poly_reg <= table_poly_next;
            b_valid_reg    <= b_valid_next;
            m_valid_reg    <= m_valid_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = crc_reg;

`ifndef SYNTHESIS
    // an item is only taken against a table built for the current polynomial
    a_accept_fresh_table: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (state_reg == ST_RUN) && (table_poly_reg == eff_poly))
        else $error("item accepted with a stale crc table");

    // the lookup stage is empty for the whole rebuild
    a_build_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD) |-> !b_valid_reg)
        else $error("lookup stage busy during table rebuild");

    // table data held while the lookup stage waits on the output
    a_lookup_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> $stable(rd_data) && b_valid_reg)
        else $error("stalled lookup lost its table data");

    // a finished lookup always lands in the output register
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        b_adv |=> m_valid_reg && (crc_reg == $past(fwd_crc)))
        else $error("lookup result not delivered to output register");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the reflected crc-32 engine
// ----------------------------------------------------------------------------
// Items are queued by the stimulus process and handed to the engine by a
// clocked driver. Every accepted byte is folded into a shadow crc, which is
// kept against its own lookup table and polynomial. The clocked monitor
// compares each returned crc with the oldest shadow value. A short directed
// set runs first. Random buffers then follow under a series of generator
// polynomials, and each polynomial is written while the engine is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc32te_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int IDLE_PCT      = 31;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_AT       = 350;
    localparam int HOLD_LEN      = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_POLYS     = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic [CRC_W-1:0]  start_value;
    } byte_item_t;

    // engine ports; the inputs are all known from time zero
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CRC_W-1:0]  cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte   = '0;
    logic              s_first_byte  = 1'b0;
    logic [CRC_W-1:0]  s_start_value = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [CRC_W-1:0]  m_crc_value;

    // bytes waiting for the driver, crcs waiting for the monitor
    byte_item_t       byte_q[$];
    logic [CRC_W-1:0] crc_expected_q[$];

    // shadow copy of the engine state
    logic [CRC_W-1:0] poly_shadow = DEFAULT_POLY;
    logic [CRC_W-1:0] lut_poly    = '0;
    logic [CRC_W-1:0] crc_shadow  = '0;
    logic [CRC_W-1:0] crc_lut [TABLE_DEPTH];

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned crcs_checked = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          steady       = 1'b0;

    crc32_table_driven_engine_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_start_value (s_start_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_crc_value   (m_crc_value)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // shadow crc
    // ------------------------------------------------------------------------

    function automatic logic [CRC_W-1:0] flip_word(input logic [CRC_W-1:0] w);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[CRC_W-1-k] = w[k];
        end
        return r;
    endfunction

    // the msb-first build with a reflected result is the same as an lsb-first
    // build with the reflected polynomial, so the table is filled that way
    function automatic void rebuild_lut(input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] rpoly;
        logic [CRC_W-1:0] c;
        rpoly = flip_word(poly);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            c = CRC_W'(i);
            for (int b = 0; b < BYTE_W; b++) begin
                c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
            end
            crc_lut[i] = c;
        end
        lut_poly = poly;
    endfunction

    // fold one accepted byte into the shadow crc and return the new value
    function automatic logic [CRC_W-1:0] fold_byte(input byte_item_t it);
        logic [CRC_W-1:0] eff_poly;
        logic [CRC_W-1:0] prior;
        eff_poly = (poly_shadow == '0) ? DEFAULT_POLY : poly_shadow;
        // a new polynomial takes effect at once, even in the middle of a buffer
        if (eff_poly != lut_poly) begin
            rebuild_lut(eff_poly);
        end
        prior = it.first_byte ? it.start_value : crc_shadow;
        crc_shadow = crc_lut[prior[BYTE_W-1:0] ^ it.data_byte] ^ (prior >> BYTE_W);
        return crc_shadow;
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        byte_item_t taken;
        byte_item_t nxt;
        logic       holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // an offered item stays put until the engine takes it
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                taken.data_byte   = s_data_byte;
                taken.first_byte  = s_first_byte;
                taken.start_value = s_start_value;
                crc_expected_q.push_back(fold_byte(taken));
                bytes_taken++;
            end
            if (!holding) begin
                if (byte_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = byte_q.pop_front();
                    s_valid       <= 1'b1;
                    s_data_byte   <= nxt.data_byte;
                    s_first_byte  <= nxt.first_byte;
                    s_start_value <= nxt.start_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor and receiver back-pressure
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        logic [CRC_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (crc_expected_q.size() == 0) begin
                    $display("%0t: crc %08h returned with no item outstanding",
                             $time, m_crc_value);
                    error_count++;
                end else begin
                    want = crc_expected_q.pop_front();
                    if (m_crc_value !== want) begin
                        $display("%0t: crc_value mismatch, expected %08h actual %08h",
                                 $time, want, m_crc_value);
                        error_count++;
                    end
                end
                crcs_checked++;
            end
            // one long hold-off part way through, so the engine backs up and
            // drops s_ready while the driver keeps offering
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && crcs_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top: run stopped after %0d cycles, %0d crcs still outstanding",
                     cycle_count, crc_expected_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic push_item(input logic [BYTE_W-1:0] data_byte,
                             input logic              first_byte,
                             input logic [CRC_W-1:0]  start_value);
        byte_item_t it;
        it.data_byte   = data_byte;
        it.first_byte  = first_byte;
        it.start_value = start_value;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    // quiet point: everything taken, every crc back, pipeline drained
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || crc_expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [CRC_W-1:0] poly_plan [NUM_POLYS];
        string            check_msg;
        int               left;
        int               len;
        bit               phase_start;
        logic             first_flag;

        check_msg = "123456789";
        // zero selects the default, then all-ones, the lone low and high bits,
        // a random one, a common alternative, and finally the reset value again
        poly_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                      $urandom(), 32'h1EDC_6F41, DEFAULT_POLY};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed set under the reset polynomial
        // continuing straight after reset runs on from a zero crc, start ignored
        push_item(8'hA5, 1'b0, 32'hDEAD_BEEF);
        push_item(8'h00, 1'b0, 32'hFFFF_FFFF);
        // extremes of byte and start value
        push_item(8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_item(8'h00, 1'b1, 32'h0000_0000);
        push_item(8'hFF, 1'b1, 32'h0000_0000);
        push_item(8'h00, 1'b1, 32'hFFFF_FFFF);
        // the usual check string from the all-ones preset
        for (int i = 0; i < check_msg.len(); i++) begin
            push_item(check_msg[i], i == 0, 32'hFFFF_FFFF);
        end
        push_item(8'h80, 1'b1, 32'h8000_0000);
        // start value must have no effect without the start flag
        push_item(8'h01, 1'b0, 32'h0000_0001);
        push_item(8'h7F, 1'b1, 32'h0000_0001);
        push_item(8'hFE, 1'b0, 32'hFFFF_FFFE);
        push_item(8'h55, 1'b1, 32'hAAAA_AAAA);

        for (int p = 0; p < NUM_POLYS; p++) begin
            wait_idle();
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= poly_plan[p];
            poly_shadow = poly_plan[p];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            // one phase runs with no idling on either side
            steady = (p == 3);

            // random buffers; the first one carries on across the polynomial
            // change, some start flags are scattered at random as noise
            left = PHASE_ITEMS;
            phase_start = 1'b1;
            while (left > 0) begin
                len = $urandom_range(1, 24);
                for (int k = 0; k < len && left > 0; k++) begin
                    first_flag = (k == 0) && !phase_start;
                    if ($urandom_range(99) < 12) begin
                        first_flag = 1'($urandom_range(1));
                    end
                    push_item(BYTE_W'($urandom_range(255)), first_flag, $urandom());
                    left--;
                end
                phase_start = 1'b0;
            end
        end
        wait_idle();

        $display("tb_top: %0d bytes folded, %0d crcs compared, %0d polynomial settings",
                 bytes_taken, crcs_checked, NUM_POLYS + 1);
        $display("tb_top: %0d mismatches, one %0d-cycle receiver hold-off",
                 error_count, HOLD_LEN);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/crc32te_pkg.sv
hdl/crc32te_ram.sv
hdl/crc32_table_driven_engine_core.sv
test/tb_top.sv
